@@ rtl/sita_pkg.sv @@
// Shared types, constants and helpers for the integer-to-ASCII converter.
`timescale 1ns / 1ps

package sita_pkg;

    localparam int VALUE_W      = 16;
    localparam int RADIX_W      = 5;
    localparam int DIGIT_W      = 4;
    localparam int CHAR_W       = 8;
    localparam int RESULT_LIMIT = 16;
    localparam int SENT_W       = $clog2(RESULT_LIMIT + 1);

    // divider resolves this many quotient bits per clock
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = VALUE_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // register indexes
    localparam logic REG_RADIX = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWA  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_FETCH,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic load;        // capture new value, clear digit count
        logic div_step;    // one divider step
        logic commit;      // last divider cycle: store digit, restart remainder
        logic send_sign;   // put '-' on the output
        logic send_digit;  // put the fetched digit on the output
    } cmd_t;

    typedef struct packed {
        logic quot_zero;   // quotient after this divider cycle is zero
        logic store_full;  // digit store has one free slot left
        logic negative;
        logic last_char;   // digit being sent ends the text
    } status_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10)
            glyph = CHAR_ZERO + dx;
        else
            glyph = CHAR_LOWA + dx - 8'd10;
    endfunction

endpackage

@@ rtl/sita_regs.sv @@
// APB register file: holds the radix register and its clamped form.
`timescale 1ns / 1ps

module sita_regs
    import sita_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [RADIX_W-1:0] base
);

    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_next;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RADIX);

    always_comb
    begin
        radix_next = radix_reg;
        if (wr_en)
            radix_next = pwdata[RADIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else
            radix_reg <= radix_next;
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_RADIX)
            prdata = {{(32-RADIX_W){1'b0}}, radix_reg};
    end

    // out-of-range codes fold to the nearest legal base
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            base = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            base = RADIX_MAX;
        else
            base = radix_reg;
    end

endmodule

@@ rtl/sita_ctrl.sv @@
// Controller state machine: sequences divide, sign and digit transfers.
`timescale 1ns / 1ps

module sita_ctrl
    import sita_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] step_reg;
    logic [DIV_CNT_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    cmd.commit = 1'b1;
                    step_next  = '0;
                    if (status.quot_zero || status.store_full)
                        state_next = status.negative ? ST_SIGN : ST_FETCH;
                end
            end
            ST_SIGN:
            begin
                // digit read for the top digit runs in this cycle too
                cmd.send_sign = 1'b1;
                state_next    = ST_SEND;
            end
            ST_FETCH:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                cmd.send_digit = 1'b1;
                state_next     = status.last_char ? ST_IDLE : ST_FETCH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/sita_dp.sv @@
// Datapath: shared radix divider, digit store and output register.
`timescale 1ns / 1ps

module sita_dp
    import sita_pkg::*;
#(
    parameter int DIGIT_SLOTS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [RADIX_W-1:0]         base,
    output status_t                    status,
    output logic                       char_valid,
    output logic [CHAR_W-1:0]          character,
    output logic                       last
);

    localparam int AW = $clog2(DIGIT_SLOTS);
    localparam int CW = $clog2(DIGIT_SLOTS + 1);

    logic [VALUE_W-1:0] div_reg,  div_next;
    logic [RADIX_W-1:0] rem_reg,  rem_next;
    logic [RADIX_W-1:0] base_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      ptr_reg;
    logic [SENT_W-1:0]  sent_reg;
    logic               neg_reg;

    logic [DIGIT_W-1:0] digit_mem [DIGIT_SLOTS];
    logic [DIGIT_W-1:0] rd_data_reg;

    logic               valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [VALUE_W-1:0] mag;

    // two's-complement magnitude; -32768 lands on 0x8000 naturally
    assign mag = value[VALUE_W-1] ? (~value + 1'b1) : value;

    // restoring division, four quotient bits per cycle
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        logic [VALUE_W-1:0] d;
        r = rem_reg;
        d = div_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            r = {r[RADIX_W-2:0], d[VALUE_W-1]};
            d = {d[VALUE_W-2:0], 1'b0};
            if (r >= base_reg)
            begin
                r    = r - base_reg;
                d[0] = 1'b1;
            end
        end
        div_next = d;
        rem_next = r;
    end

    assign status.quot_zero  = (div_next == '0);
    assign status.store_full = (count_reg == CW'(DIGIT_SLOTS - 1));
    assign status.negative   = neg_reg;
    assign status.last_char  = (ptr_reg == '0) ||
                               (sent_reg == SENT_W'(RESULT_LIMIT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            neg_reg   <= 1'b0;
            valid_reg <= 1'b0;
            sent_reg  <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= cmd.send_sign || cmd.send_digit;
            if (cmd.load)
            begin
                count_reg <= '0;
                neg_reg   <= value[VALUE_W-1];
                sent_reg  <= '0;
            end
            if (cmd.commit)
            begin
                count_reg <= count_reg + 1'b1;
                ptr_reg   <= count_reg[AW-1:0];   // index of the newest digit
            end
            if (cmd.send_sign || cmd.send_digit)
                sent_reg <= sent_reg + 1'b1;
            if (cmd.send_digit)
                ptr_reg <= ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg  <= mag;
            rem_reg  <= '0;
            base_reg <= base;
        end
        else if (cmd.div_step)
        begin
            div_reg <= div_next;
            rem_reg <= cmd.commit ? '0 : rem_next;
        end
        if (cmd.send_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.send_digit)
        begin
            char_reg <= glyph(rd_data_reg);
            last_reg <= status.last_char;
        end
    end

    // digit store, least significant digit at index zero
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            digit_mem[count_reg[AW-1:0]] <= rem_next[DIGIT_W-1:0];
        rd_data_reg <= digit_mem[ptr_reg];
    end

    assign char_valid = valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;

endmodule

@@ rtl/short_int_to_ascii_base_core.sv @@
// Top level of the signed 16-bit integer to ASCII text converter.
`timescale 1ns / 1ps

// Converts one signed 16-bit value per start into its text form in the base
// held by the radix register (2..16; codes 0 and 1 act as 2, codes above 16
// act as 16). Characters leave most significant digit first, one per
// char_valid pulse, with '-' ahead of negative values and lower-case letters
// for digits above nine. The final character of a number has last set; no
// terminator follows. Text longer than sixteen characters (only -32768 in
// base 2) is cut to its first sixteen, last set on the sixteenth.
// The output side cannot stall: each character is on character/last for
// exactly one cycle while char_valid is high and must be taken then.
// A value is accepted on a clock edge with start high and busy low.
// While busy is high the block divides out each digit (the shared divider
// resolves four quotient bits per cycle) and then transfers the digits, each
// as a digit store read followed by an output register load. The '-' of a
// negative value goes out in the cycle that reads the top digit, in place of
// a separate read step. The last character appears in the first cycle with
// busy low, and start may already be high in that cycle.
// The radix register sits at byte address 0 of the APB port; write it only
// while busy is low.

module short_int_to_ascii_base_core
    import sita_pkg::*;
#(
    parameter int DIGIT_SLOTS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // command side
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] value,
    // result side, one transfer per char_valid pulse
    output logic                      char_valid,
    output logic [CHAR_W-1:0]         character,
    output logic                      last,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    cmd_t               cmd;
    status_t            status;
    logic [RADIX_W-1:0] base;

    sita_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .base    (base)
    );

    sita_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sita_dp #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .base       (base),
        .status     (status),
        .char_valid (char_valid),
        .character  (character),
        .last       (last)
    );

endmodule

@@ verif/tb_short_int_to_ascii_base_core.sv @@
// Testbench for short_int_to_ascii_base_core: predicted text stream vs. DUT characters.
`timescale 1ns / 1ps

// What is exercised
//   - Values go in through the start/busy command port. Characters come back
//     on char_valid/character/last, and that side cannot be stalled.
//   - The radix register moves through the default (10), both ends of the
//     legal range (2, 16), the clamped codes (0, 1, 17, 31), writes with
//     junk in the upper data bits, and writes to the unused register slot.
//     The unused-slot writes must not change anything.
//   - Directed values: zero, +/-1, the ends of the 16-bit range, and letter
//     digits in base 16. They include -32768 in base 2, where the text is
//     cut to sixteen characters.
//   - About 450 random values are then sent in phases, each phase under a
//     new radix setting.
// How it is checked
//   - At each accepted transfer the monitor formats the value in its own
//     copy of the radix setting and queues the expected characters.
//   - Each char_valid pulse is compared, field by field, with the oldest
//     queued character.
//   - Radix writes happen only while the block is idle, that is, once
//     every queued character has come out.

module tb_short_int_to_ascii_base_core;
    import sita_pkg::*;

    localparam time CLK_HALF = 10ns;

    // byte addresses: register index times four
    localparam logic [2:0] RADIX_ADDR  = {REG_RADIX, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = {~REG_RADIX, 2'b00};

    typedef struct packed {
        logic [CHAR_W-1:0] ascii;
        logic              last;
    } text_char_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      start      = 1'b0;
    logic signed [VALUE_W-1:0] value      = '0;
    logic                      busy;
    logic                      char_valid;
    logic [CHAR_W-1:0]         character;
    logic                      last;
    logic                      psel       = 1'b0;
    logic                      penable    = 1'b0;
    logic                      pwrite     = 1'b0;
    logic [2:0]                paddr      = '0;
    logic [31:0]               pwdata     = '0;
    logic [31:0]               prdata;
    logic                      pready;

    // values waiting to be driven, and characters the DUT still owes us
    logic [VALUE_W-1:0] pending_values[$];
    text_char_t         text_expected[$];

    // testbench copy of the radix register
    logic [RADIX_W-1:0] radix_setting = RADIX_RESET;

    bit gaps_on = 1'b1;
    int mismatches = 0;
    int values_sent = 0;
    int chars_checked = 0;
    int radix_writes = 0;

    short_int_to_ascii_base_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .char_valid (char_valid),
        .character  (character),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(CLK_HALF) clk = ~clk;

    // Expected text for one value: optional '-', then digits MSD first.
    // Only the first RESULT_LIMIT characters survive, which matters only for
    // -32768 in base 2.
    function automatic void format_value(input logic [VALUE_W-1:0] raw,
                                         input logic [RADIX_W-1:0] code);
        logic [VALUE_W-1:0] mag;
        logic [RADIX_W-1:0] base;
        logic [DIGIT_W-1:0] digits [RESULT_LIMIT];
        logic [DIGIT_W-1:0] d;
        int                 count;
        int                 sent;
        int                 k;
        text_char_t         tc;
        base = (code < RADIX_MIN) ? RADIX_MIN : (code > RADIX_MAX) ? RADIX_MAX : code;
        // two's-complement negate; -32768 comes out as 0x8000, the true magnitude
        mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        // at least one digit, so zero gives "0"
        for (count = 0; count == 0 || (mag != 0 && count < RESULT_LIMIT); count++)
        begin
            digits[count] = DIGIT_W'(mag % base);
            mag = mag / base;
        end
        sent = 0;
        if (raw[VALUE_W-1])
        begin
            tc.ascii = CHAR_MINUS;
            tc.last  = 1'b0;
            text_expected.push_back(tc);
            sent++;
        end
        for (k = count; k > 0 && sent < RESULT_LIMIT; k--)
        begin
            d = digits[k-1];
            tc.ascii = (d < 4'd10) ? CHAR_ZERO + CHAR_W'(d)
                                   : CHAR_LOWA + CHAR_W'(d) - 8'd10;
            tc.last  = 1'b0;
            text_expected.push_back(tc);
            sent++;
        end
        text_expected[text_expected.size()-1].last = 1'b1;
    endfunction

    // Driver: start stays up until the transfer is taken, then the next value
    // follows at once unless a random gap is rolled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            value <= '0;
        end
        else if (!start || !busy)
        begin
            if (pending_values.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 7))
            begin
                start <= 1'b1;
                value <= pending_values.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check this cycle's character, then predict the text of any
    // value taken at this edge. A value's first character can never arrive
    // at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid)
            begin
                if (text_expected.size() == 0)
                begin
                    $display("%0t: unexpected character %h (last %0d), nothing pending",
                             $time, character, last);
                    mismatches++;
                end
                else
                begin
                    if (character !== text_expected[0].ascii)
                    begin
                        $display("%0t: character mismatch: expected %h, got %h",
                                 $time, text_expected[0].ascii, character);
                        mismatches++;
                    end
                    if (last !== text_expected[0].last)
                    begin
                        $display("%0t: last mismatch: expected %0d, got %0d",
                                 $time, text_expected[0].last, last);
                        mismatches++;
                    end
                    void'(text_expected.pop_front());
                    chars_checked++;
                end
            end
            if (start && !busy)
            begin
                format_value(value, radix_setting);
                values_sent++;
            end
        end
    end

    // APB write: a setup cycle, then an access cycle. The write lands at the
    // edge that closes the access cycle, because pready is always high.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == RADIX_ADDR)
        begin
            radix_setting = data[RADIX_W-1:0];
            radix_writes++;
        end
        @(negedge clk);
    endtask

    // Idle means: every value has been driven and taken, and every character
    // has arrived. After that, let the block settle before going on.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_values.size() != 0 || start || text_expected.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [RADIX_W-1:0] phase_codes [8];
        logic [RADIX_W-1:0] code;
        logic [VALUE_W-1:0] v;
        int                 p;
        int                 i;
        phase_codes = '{5'd1, 5'd17, 5'd3, 5'd10, 5'd0, 5'd31, 5'd16, 5'd2};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part.
        // Reset radix (10): zero, +/-1, one and two digits, both range ends.
        pending_values = '{16'd0, 16'd1, -16'd1, 16'd9, -16'd10, 16'h7fff, 16'h8000,
                           -16'd12345};
        wait_idle();
        // Base 2: -32768 is cut to sixteen characters; 32767 gives fifteen ones.
        apb_write(RADIX_ADDR, 32'd2);
        pending_values = '{16'h8000, 16'h7fff, 16'd0, -16'd1};
        wait_idle();
        // Base 16: letter digits a through f.
        apb_write(RADIX_ADDR, 32'd16);
        pending_values = '{16'h8000, 16'h7abc, 16'h7def, -16'd255};
        wait_idle();
        // Code 0 is clamped up to base 2.
        apb_write(RADIX_ADDR, 32'd0);
        pending_values = '{16'd5, -16'd6};
        wait_idle();
        // Code 31 is clamped down to base 16.
        apb_write(RADIX_ADDR, 32'd31);
        pending_values = '{16'd255};
        wait_idle();
        // A write to the unused slot must leave the radix at 31.
        apb_write(UNUSED_ADDR, 32'd3);
        pending_values = '{16'd255};
        wait_idle();

        // Random part: nine phases of 50 values, each under its own radix.
        // The phase under radix 10 runs with no input gaps at all.
        for (p = 0; p < 9; p++)
        begin
            code = (p < 8) ? phase_codes[p] : RADIX_W'($urandom_range(0, 31));
            if ($urandom_range(0, 2) == 0)
                apb_write(UNUSED_ADDR, $urandom());
            // junk above the five register bits must be dropped
            apb_write(RADIX_ADDR, ($urandom() & ~32'h1f) | 32'(code));
            gaps_on = (p != 3);
            for (i = 0; i < 50; i++)
            begin
                case ($urandom_range(0, 7))
                    0:
                    begin
                        case ($urandom_range(0, 4))
                            0:       v = 16'h8000;
                            1:       v = 16'h7fff;
                            2:       v = 16'h0000;
                            3:       v = 16'hffff;
                            default: v = 16'h0001;
                        endcase
                    end
                    1, 2:
                    begin
                        v = VALUE_W'($urandom_range(0, 300));
                        if ($urandom_range(0, 1) == 1)
                            v = -v;
                    end
                    default: v = VALUE_W'($urandom());
                endcase
                pending_values.push_back(v);
            end
            wait_idle();
        end
        gaps_on = 1'b1;

        repeat (20) @(posedge clk);
        $display("Run covered %0d values under %0d radix writes; %0d characters checked.",
                 values_sent, radix_writes, chars_checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog. 20 ms is well beyond the length of a correct run, even with
    // every value at sixteen characters.
    initial
    begin
        #20ms;
        $display("Timeout with %0d characters still pending", text_expected.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
